### design/assert_macros.svh
// Assertion macros shared by the executor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold whenever the antecedent holds (same cycle).
`define ASSERT_IMPLY(lbl, aclk, arst_n, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!arst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Condition must never be true at a clock edge.
`define ASSERT_NEVER(lbl, aclk, arst_n, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!arst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`endif

### design/sm83lq_pkg.sv
// Shared types, codes and constants of the SM83 low-quadrant executor.
package sm83lq_pkg;

    // Stream widths
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 64;
    localparam int RES_BITS = 57;

    // Queue between decode and execute
    localparam int QUEUE_DEPTH_DEF = 2;

    // Bus access codes
    localparam logic [1:0] BUS_NONE  = 2'd0;
    localparam logic [1:0] BUS_READ  = 2'd1;
    localparam logic [1:0] BUS_WRITE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNSUP    = 2'd1;
    localparam logic [1:0] ST_BAD_KIND = 2'd2;

    // Flag bit positions (Z N H C)
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // Reset values
    localparam logic [15:0] PC_RESET = 16'h0100;
    localparam logic [15:0] SP_RESET = 16'hFFFE;
    localparam logic [7:0]  A_RESET  = 8'h01;
    localparam logic [3:0]  F_RESET  = 4'hB;
    localparam logic [15:0] BC_RESET = 16'h0013;
    localparam logic [15:0] DE_RESET = 16'h00D8;
    localparam logic [15:0] HL_RESET = 16'h014D;

    // 8-bit register codes from opcode bits 5:3
    localparam logic [2:0] REG_B   = 3'd0;
    localparam logic [2:0] REG_C   = 3'd1;
    localparam logic [2:0] REG_D   = 3'd2;
    localparam logic [2:0] REG_E   = 3'd3;
    localparam logic [2:0] REG_H   = 3'd4;
    localparam logic [2:0] REG_L   = 3'd5;
    localparam logic [2:0] REG_MEM = 3'd6;
    localparam logic [2:0] REG_A   = 3'd7;

    // Register pair codes from opcode bits 5:4
    localparam logic [1:0] PAIR_BC = 2'd0;
    localparam logic [1:0] PAIR_DE = 2'd1;
    localparam logic [1:0] PAIR_HL = 2'd2;
    localparam logic [1:0] PAIR_SP = 2'd3;

    // Relative jump conditions from opcode bits 5:3
    localparam logic [2:0] JRC_ALWAYS = 3'd3;
    localparam logic [2:0] JRC_NZ     = 3'd4;
    localparam logic [2:0] JRC_Z      = 3'd5;
    localparam logic [2:0] JRC_NC     = 3'd6;
    localparam logic [2:0] JRC_C      = 3'd7;

    // Opcodes decoded one by one
    localparam logic [7:0] OP_NOP       = 8'h00;
    localparam logic [7:0] OP_LD_A16_SP = 8'h08;
    localparam logic [7:0] OP_STOP      = 8'h10;
    localparam logic [7:0] OP_JR        = 8'h18;
    localparam logic [7:0] OP_JR_NZ     = 8'h20;
    localparam logic [7:0] OP_JR_Z      = 8'h28;
    localparam logic [7:0] OP_JR_NC     = 8'h30;
    localparam logic [7:0] OP_JR_C      = 8'h38;
    localparam logic [7:0] OP_RLCA      = 8'h07;
    localparam logic [7:0] OP_RRCA      = 8'h0F;
    localparam logic [7:0] OP_RLA       = 8'h17;
    localparam logic [7:0] OP_RRA       = 8'h1F;
    localparam logic [7:0] OP_DAA       = 8'h27;
    localparam logic [7:0] OP_CPL       = 8'h2F;
    localparam logic [7:0] OP_SCF       = 8'h37;
    localparam logic [7:0] OP_CCF       = 8'h3F;

    // DAA adjust constants
    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [7:0] DAA_HI_MAX = 8'h99;
    localparam logic [3:0] DAA_LO_MAX = 4'h9;

    // Instruction classes produced by decode
    typedef enum logic [4:0] {
        CLS_UNSUP,
        CLS_RESP,
        CLS_NOP,
        CLS_LDSP,
        CLS_STOP,
        CLS_JR,
        CLS_LD16,
        CLS_STORE,
        CLS_LOAD,
        CLS_INC16,
        CLS_DEC16,
        CLS_INC8,
        CLS_DEC8,
        CLS_INCM,
        CLS_DECM,
        CLS_LD8,
        CLS_STM,
        CLS_RLCA,
        CLS_RRCA,
        CLS_RLA,
        CLS_RRA,
        CLS_DAA,
        CLS_CPL,
        CLS_SCF,
        CLS_CCF
    } cls_t;

    // One decoded item as it sits in the queue
    typedef struct packed {
        cls_t        cls;
        logic [1:0]  row;
        logic [2:0]  code;
        logic [1:0]  len;
        logic [15:0] imm;
        logic [7:0]  rdata;
    } uop_t;

endpackage

### design/sm83lq_decode.sv
// Front end: accepts stream transactions and classifies them into queue entries.
module sm83lq_decode (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sm83lq_pkg::S_DATA_W-1:0] s_tdata,  // opcode[7:0], immediate[23:8], read_data[31:24]
    input  logic                           s_tuser,  // kind
    input  logic                           q_full,
    output logic                           push,
    output sm83lq_pkg::uop_t               uop
);
    import sm83lq_pkg::*;

    logic [7:0] opc;
    logic [3:0] col;

    assign opc      = s_tdata[7:0];
    assign col      = opc[3:0];
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // Opcode classification and instruction length
    always_comb
    begin
        uop.cls   = CLS_UNSUP;
        uop.row   = opc[5:4];
        uop.code  = opc[5:3];
        uop.len   = 2'd0;
        uop.imm   = s_tdata[23:8];
        uop.rdata = s_tdata[31:24];
        if (s_tuser) begin
            uop.cls = CLS_RESP;
        end
        else if (opc[7:6] != 2'b00 || col == 4'h9) begin
            uop.cls = CLS_UNSUP;
        end
        else begin
            case (col)
                4'h0, 4'h8:
                begin
                    case (opc)
                        OP_NOP:
                        begin
                            uop.cls = CLS_NOP;
                            uop.len = 2'd1;
                        end
                        OP_LD_A16_SP:
                        begin
                            uop.cls = CLS_LDSP;
                            uop.len = 2'd3;
                        end
                        OP_STOP:
                        begin
                            uop.cls = CLS_STOP;
                            uop.len = 2'd2;
                        end
                        OP_JR, OP_JR_NZ, OP_JR_Z, OP_JR_NC, OP_JR_C:
                        begin
                            uop.cls = CLS_JR;
                            uop.len = 2'd2;
                        end
                        default: uop.cls = CLS_UNSUP;
                    endcase
                end
                4'h1:
                begin
                    uop.cls = CLS_LD16;
                    uop.len = 2'd3;
                end
                4'h2:
                begin
                    uop.cls = CLS_STORE;
                    uop.len = 2'd1;
                end
                4'hA:
                begin
                    uop.cls = CLS_LOAD;
                    uop.len = 2'd1;
                end
                4'h3:
                begin
                    uop.cls = CLS_INC16;
                    uop.len = 2'd1;
                end
                4'hB:
                begin
                    uop.cls = CLS_DEC16;
                    uop.len = 2'd1;
                end
                4'h4, 4'hC:
                begin
                    uop.cls = (opc[5:3] == REG_MEM) ? CLS_INCM : CLS_INC8;
                    uop.len = 2'd1;
                end
                4'h5, 4'hD:
                begin
                    uop.cls = (opc[5:3] == REG_MEM) ? CLS_DECM : CLS_DEC8;
                    uop.len = 2'd1;
                end
                4'h6, 4'hE:
                begin
                    uop.cls = (opc[5:3] == REG_MEM) ? CLS_STM : CLS_LD8;
                    uop.len = 2'd2;
                end
                4'h7, 4'hF:
                begin
                    uop.len = 2'd1;
                    case (opc)
                        OP_RLCA: uop.cls = CLS_RLCA;
                        OP_RRCA: uop.cls = CLS_RRCA;
                        OP_RLA:  uop.cls = CLS_RLA;
                        OP_RRA:  uop.cls = CLS_RRA;
                        OP_DAA:  uop.cls = CLS_DAA;
                        OP_CPL:  uop.cls = CLS_CPL;
                        OP_SCF:  uop.cls = CLS_SCF;
                        OP_CCF:  uop.cls = CLS_CCF;
                        default: uop.cls = CLS_UNSUP;
                    endcase
                end
                default: uop.cls = CLS_UNSUP;
            endcase
        end
    end

endmodule

### design/sm83lq_fifo.sv
// Short queue of decoded items between the front end and the execute stage.
module sm83lq_fifo #(
    parameter int DEPTH = sm83lq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sm83lq_pkg::uop_t push_uop,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output sm83lq_pkg::uop_t head_uop
);
    import sm83lq_pkg::*;

    `include "assert_macros.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    uop_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_uop   = entries_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_uop;
        end
    end

    `ASSERT_NEVER(a_no_overflow, clk, rst_n, push && full)
    `ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && !head_valid)

endmodule

### design/sm83lq_execute.sv
// Back end: executes queued items on the CPU state and registers the results.
module sm83lq_execute (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  sm83lq_pkg::uop_t                q_uop,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sm83lq_pkg::M_DATA_W-1:0] m_tdata,  // bus_op[1:0], bus_addr[17:2],
                                                      // bus_wdata[25:18], status[27:26],
                                                      // prog_counter[43:28], accumulator[51:44],
                                                      // flag_bits[55:52], is_stopped[56]
    output logic                            m_tlast   // last
);
    import sm83lq_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_LOAD_A,
        PEND_INC_M,
        PEND_DEC_M
    } pend_t;

    // Architectural state
    logic [15:0] pc_reg, pc_next;
    logic [15:0] sp_reg, sp_next;
    logic [7:0]  a_reg, a_next;
    logic [7:0]  b_reg, b_next;
    logic [7:0]  c_reg, c_next;
    logic [7:0]  d_reg, d_next;
    logic [7:0]  e_reg, e_next;
    logic [7:0]  h_reg, h_next;
    logic [7:0]  l_reg, l_next;
    logic [3:0]  f_reg, f_next;
    logic        stop_reg, stop_next;
    pend_t       pend_reg, pend_next;

    // Second half of LD (a16),SP still owed
    logic        phase2_reg, phase2_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;

    // Result fields of the current step
    logic [1:0]  r_op;
    logic [15:0] r_addr;
    logic [7:0]  r_wdata;
    logic [1:0]  r_status;
    logic        r_last;

    logic        adv;
    logic        issue;
    logic        is_double;
    logic [15:0] hl;
    logic [15:0] pair_val;
    logic [15:0] pc_step;
    logic [7:0]  r8;
    logic [7:0]  v8;
    logic [7:0]  daa_adj;
    logic [7:0]  daa_res;
    logic        daa_c;
    logic        take;
    logic        cin;

    assign hl        = {h_reg, l_reg};
    assign pc_step   = pc_reg + {14'd0, q_uop.len};
    assign cin       = f_reg[FLAG_C];
    assign adv       = !out_valid_reg || m_tready;
    assign issue     = adv && (phase2_reg || q_valid);
    assign is_double = (q_uop.cls == CLS_LDSP) && (pend_reg == PEND_NONE);
    assign pop       = issue && (phase2_reg || !is_double);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Operand selection
    always_comb
    begin
        case (q_uop.row)
            PAIR_BC: pair_val = {b_reg, c_reg};
            PAIR_DE: pair_val = {d_reg, e_reg};
            PAIR_HL: pair_val = hl;
            default: pair_val = sp_reg;
        endcase
        case (q_uop.code)
            REG_B:   r8 = b_reg;
            REG_C:   r8 = c_reg;
            REG_D:   r8 = d_reg;
            REG_E:   r8 = e_reg;
            REG_H:   r8 = h_reg;
            REG_L:   r8 = l_reg;
            REG_A:   r8 = a_reg;
            default: r8 = 8'h00;
        endcase
        case (q_uop.code)
            JRC_ALWAYS: take = 1'b1;
            JRC_NZ:     take = !f_reg[FLAG_Z];
            JRC_Z:      take = f_reg[FLAG_Z];
            JRC_NC:     take = !f_reg[FLAG_C];
            default:    take = f_reg[FLAG_C];
        endcase
    end

    // Decimal adjust of A
    always_comb
    begin
        daa_adj = 8'h00;
        daa_c   = f_reg[FLAG_C];
        if (f_reg[FLAG_N]) begin
            if (f_reg[FLAG_H]) daa_adj = daa_adj | DAA_LO_ADJ;
            if (f_reg[FLAG_C]) daa_adj = daa_adj | DAA_HI_ADJ;
            daa_res = a_reg - daa_adj;
        end
        else begin
            if (f_reg[FLAG_H] || a_reg[3:0] > DAA_LO_MAX) daa_adj = daa_adj | DAA_LO_ADJ;
            if (f_reg[FLAG_C] || a_reg > DAA_HI_MAX) begin
                daa_adj = daa_adj | DAA_HI_ADJ;
                daa_c   = 1'b1;
            end
            daa_res = a_reg + daa_adj;
        end
    end

    // Execute one step
    always_comb
    begin
        pc_next   = pc_reg;
        sp_next   = sp_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        d_next    = d_reg;
        e_next    = e_reg;
        h_next    = h_reg;
        l_next    = l_reg;
        f_next    = f_reg;
        stop_next = stop_reg;
        pend_next = pend_reg;
        r_op      = BUS_NONE;
        r_addr    = 16'h0000;
        r_wdata   = 8'h00;
        r_status  = ST_OK;
        r_last    = 1'b1;
        v8        = 8'h00;

        if (phase2_reg) begin
            // high byte of SP, state already updated
            r_op    = BUS_WRITE;
            r_addr  = q_uop.imm + 16'd1;
            r_wdata = sp_reg[15:8];
        end
        else if (q_uop.cls == CLS_RESP) begin
            case (pend_reg)
                PEND_NONE:   r_status = ST_BAD_KIND;
                PEND_LOAD_A:
                begin
                    a_next    = q_uop.rdata;
                    pend_next = PEND_NONE;
                end
                PEND_INC_M:
                begin
                    v8        = q_uop.rdata + 8'd1;
                    f_next    = {v8 == 8'h00, 1'b0, q_uop.rdata[3:0] == 4'hF, f_reg[FLAG_C]};
                    pend_next = PEND_NONE;
                    r_op      = BUS_WRITE;
                    r_addr    = hl;
                    r_wdata   = v8;
                end
                default:
                begin
                    v8        = q_uop.rdata - 8'd1;
                    f_next    = {v8 == 8'h00, 1'b1, q_uop.rdata[3:0] == 4'h0, f_reg[FLAG_C]};
                    pend_next = PEND_NONE;
                    r_op      = BUS_WRITE;
                    r_addr    = hl;
                    r_wdata   = v8;
                end
            endcase
        end
        else if (pend_reg != PEND_NONE) begin
            r_status = ST_BAD_KIND;
        end
        else if (q_uop.cls == CLS_UNSUP) begin
            r_status = ST_UNSUP;
        end
        else begin
            pc_next = pc_step;
            case (q_uop.cls)
                CLS_LDSP:
                begin
                    r_op    = BUS_WRITE;
                    r_addr  = q_uop.imm;
                    r_wdata = sp_reg[7:0];
                    r_last  = 1'b0;
                end
                CLS_STOP: stop_next = 1'b1;
                CLS_JR:
                begin
                    if (take) pc_next = pc_step + {{8{q_uop.imm[7]}}, q_uop.imm[7:0]};
                end
                CLS_LD16, CLS_INC16, CLS_DEC16:
                begin
                    if (q_uop.cls == CLS_LD16) begin
                        v8 = 8'h00;
                    end
                    case (q_uop.row)
                        PAIR_BC: {b_next, c_next} = (q_uop.cls == CLS_LD16) ? q_uop.imm :
                                 (q_uop.cls == CLS_INC16) ? pair_val + 16'd1 : pair_val - 16'd1;
                        PAIR_DE: {d_next, e_next} = (q_uop.cls == CLS_LD16) ? q_uop.imm :
                                 (q_uop.cls == CLS_INC16) ? pair_val + 16'd1 : pair_val - 16'd1;
                        PAIR_HL: {h_next, l_next} = (q_uop.cls == CLS_LD16) ? q_uop.imm :
                                 (q_uop.cls == CLS_INC16) ? pair_val + 16'd1 : pair_val - 16'd1;
                        default: sp_next = (q_uop.cls == CLS_LD16) ? q_uop.imm :
                                 (q_uop.cls == CLS_INC16) ? pair_val + 16'd1 : pair_val - 16'd1;
                    endcase
                end
                CLS_STORE, CLS_LOAD:
                begin
                    // (BC), (DE), (HL+), (HL-)
                    r_addr = (q_uop.row == PAIR_BC || q_uop.row == PAIR_DE) ? pair_val : hl;
                    if (q_uop.row == PAIR_HL) {h_next, l_next} = hl + 16'd1;
                    if (q_uop.row == PAIR_SP) {h_next, l_next} = hl - 16'd1;
                    if (q_uop.cls == CLS_STORE) begin
                        r_op    = BUS_WRITE;
                        r_wdata = a_reg;
                    end
                    else begin
                        r_op      = BUS_READ;
                        pend_next = PEND_LOAD_A;
                    end
                end
                CLS_INCM, CLS_DECM:
                begin
                    r_op      = BUS_READ;
                    r_addr    = hl;
                    pend_next = (q_uop.cls == CLS_INCM) ? PEND_INC_M : PEND_DEC_M;
                end
                CLS_INC8, CLS_DEC8, CLS_LD8:
                begin
                    if (q_uop.cls == CLS_INC8) begin
                        v8     = r8 + 8'd1;
                        f_next = {v8 == 8'h00, 1'b0, r8[3:0] == 4'hF, f_reg[FLAG_C]};
                    end
                    else if (q_uop.cls == CLS_DEC8) begin
                        v8     = r8 - 8'd1;
                        f_next = {v8 == 8'h00, 1'b1, r8[3:0] == 4'h0, f_reg[FLAG_C]};
                    end
                    else begin
                        v8 = q_uop.imm[7:0];
                    end
                    case (q_uop.code)
                        REG_B:   b_next = v8;
                        REG_C:   c_next = v8;
                        REG_D:   d_next = v8;
                        REG_E:   e_next = v8;
                        REG_H:   h_next = v8;
                        REG_L:   l_next = v8;
                        REG_A:   a_next = v8;
                        default: a_next = a_reg;
                    endcase
                end
                CLS_STM:
                begin
                    r_op    = BUS_WRITE;
                    r_addr  = hl;
                    r_wdata = q_uop.imm[7:0];
                end
                CLS_RLCA:
                begin
                    a_next = {a_reg[6:0], a_reg[7]};
                    f_next = {3'b000, a_reg[7]};
                end
                CLS_RRCA:
                begin
                    a_next = {a_reg[0], a_reg[7:1]};
                    f_next = {3'b000, a_reg[0]};
                end
                CLS_RLA:
                begin
                    a_next = {a_reg[6:0], cin};
                    f_next = {3'b000, a_reg[7]};
                end
                CLS_RRA:
                begin
                    a_next = {cin, a_reg[7:1]};
                    f_next = {3'b000, a_reg[0]};
                end
                CLS_DAA:
                begin
                    a_next = daa_res;
                    f_next = {daa_res == 8'h00, f_reg[FLAG_N], 1'b0, daa_c};
                end
                CLS_CPL:
                begin
                    a_next = ~a_reg;
                    f_next = {f_reg[FLAG_Z], 1'b1, 1'b1, f_reg[FLAG_C]};
                end
                CLS_SCF:  f_next = {f_reg[FLAG_Z], 3'b001};
                CLS_CCF:  f_next = {f_reg[FLAG_Z], 2'b00, !cin};
                default:  pc_next = pc_step;
            endcase
        end
    end

    // Output register load
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        phase2_next    = phase2_reg;
        if (issue) begin
            out_valid_next = 1'b1;
            out_data_next  = {{(M_DATA_W - RES_BITS){1'b0}}, stop_next, f_next, a_next,
                              pc_next, r_status, r_wdata, r_addr, r_op};
            out_last_next  = r_last;
            phase2_next    = phase2_reg ? 1'b0 : is_double;
        end
        else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pc_reg        <= PC_RESET;
            sp_reg        <= SP_RESET;
            a_reg         <= A_RESET;
            {b_reg, c_reg} <= BC_RESET;
            {d_reg, e_reg} <= DE_RESET;
            {h_reg, l_reg} <= HL_RESET;
            f_reg         <= F_RESET;
            stop_reg      <= 1'b0;
            pend_reg      <= PEND_NONE;
            phase2_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else begin
            if (issue && !phase2_reg) begin
                pc_reg   <= pc_next;
                sp_reg   <= sp_next;
                a_reg    <= a_next;
                b_reg    <= b_next;
                c_reg    <= c_next;
                d_reg    <= d_next;
                e_reg    <= e_next;
                h_reg    <= h_next;
                l_reg    <= l_next;
                f_reg    <= f_next;
                stop_reg <= stop_next;
                pend_reg <= pend_next;
            end
            phase2_reg    <= phase2_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_last_reg  <= out_last_next;
        end
    end

    // A non-final result is always followed by its second half
    `ASSERT_IMPLY(a_split_owed, clk, rst_n, out_valid_reg && !out_last_reg, phase2_reg)
    // The split instruction stays at the queue head until its second half goes out
    `ASSERT_IMPLY(a_phase2_head, clk, rst_n, phase2_reg, q_valid && q_uop.cls == CLS_LDSP)

endmodule

### design/sm83_low_quadrant_executor.sv
// Top level of the SM83 low-quadrant executor: decode, queue and execute stages.
//
// Usage:
//   Slave stream (s_*) carries one item per transaction: an instruction
//   (s_tuser = 0, opcode and immediate) or the byte answering a bus read
//   request (s_tuser = 1, read_data). Master stream (m_*) carries result
//   transactions: bus access, status and the PC, A, flags and stop state
//   after the step; m_tlast marks the final result of an input item.
//   Each accepted item is written into the queue, and the execute stage then
//   registers its result in the output register. Throughput: one item per
//   cycle while m_tready is high; LD (a16),SP yields two results. The rate
//   is set by the single output register, which moves one result per cycle.
//   The decode stage feeds a QUEUE_DEPTH entry queue, so s_tready stays high
//   while the queue has room even when m_tready is low; a stalled output
//   fills the queue and then drops s_tready.
//   Reset (rst_n low) empties the queue and output register and loads the
//   power-on CPU state: PC 0x0100, SP 0xFFFE, AF 0x01B0, BC 0x0013,
//   DE 0x00D8, HL 0x014D, no read pending, not stopped.
module sm83_low_quadrant_executor #(
    parameter int QUEUE_DEPTH = sm83lq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sm83lq_pkg::S_DATA_W-1:0] s_tdata,  // opcode[7:0], immediate[23:8],
                                                      // read_data[31:24]
    input  logic                            s_tuser,  // kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sm83lq_pkg::M_DATA_W-1:0] m_tdata,  // bus_op[1:0], bus_addr[17:2],
                                                      // bus_wdata[25:18], status[27:26],
                                                      // prog_counter[43:28], accumulator[51:44],
                                                      // flag_bits[55:52], is_stopped[56]
    output logic                            m_tlast   // last
);
    import sm83lq_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    uop_t dec_uop;
    uop_t head_uop;

    // Front end
    sm83lq_decode u_decode (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (q_push),
        .uop      (dec_uop)
    );

    // Decoupling queue
    sm83lq_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_uop   (dec_uop),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_uop   (head_uop)
    );

    // Back end
    sm83lq_execute u_execute (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_uop    (head_uop),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### tb/sm83_low_quadrant_executor_tb.sv
// Self-checking testbench: drives instruction and read-data transactions and checks every result.
`timescale 1ns / 100ps

module sm83_low_quadrant_executor_tb;

    import sm83lq_pkg::*;

    // Item kinds carried on s_tuser
    localparam logic K_INSTR = 1'b0;
    localparam logic K_RDATA = 1'b1;

    // Opcodes used in the directed part that the package does not name
    localparam logic [7:0] OP_LD_BC_D16 = 8'h01;
    localparam logic [7:0] OP_ADD_HL_BC = 8'h09;
    localparam logic [7:0] OP_LD_A_BC   = 8'h0A;
    localparam logic [7:0] OP_LD_HL_D16 = 8'h21;
    localparam logic [7:0] OP_LDI_HL_A  = 8'h22;
    localparam logic [7:0] OP_LD_SP_D16 = 8'h31;
    localparam logic [7:0] OP_INC_MEM   = 8'h34;
    localparam logic [7:0] OP_DEC_MEM   = 8'h35;
    localparam logic [7:0] OP_LD_MEM_D8 = 8'h36;
    localparam logic [7:0] OP_LDD_A_HL  = 8'h3A;
    localparam logic [7:0] OP_LD_A_D8   = 8'h3E;
    localparam logic [7:0] OP_LD_B_B    = 8'h40;
    localparam logic [7:0] OP_RST_38    = 8'hFF;

    localparam int          DIRECTED_ROWS = 28;
    localparam int          RANDOM_ITEMS  = 1300;
    localparam int          TAIL_CYCLES   = 64;
    localparam int unsigned CYCLE_LIMIT   = 600000;

    // What a memory read in flight will do with its data byte
    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_LOAD_A,
        WAIT_INC_MEM,
        WAIT_DEC_MEM
    } mem_wait_t;

    typedef struct packed {
        logic [1:0]  bus_op;
        logic [15:0] bus_addr;
        logic [7:0]  bus_wdata;
        logic [1:0]  status;
        logic [15:0] pc;
        logic [7:0]  acc;
        logic [3:0]  flags;
        logic        stopped;
        logic        last;
    } result_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  op;
        logic [15:0] imm;
        logic [7:0]  rd;
        logic        typed;
        result_t     want;
    } stim_row_t;

    localparam result_t NO_WANT = '0;

    // Directed rows; the first few have their result written out from the power-on state
    localparam stim_row_t PLAN [0:DIRECTED_ROWS-1] = '{
        '{K_INSTR, OP_NOP,       16'h0000, 8'h00, 1'b1,
          '{BUS_NONE, 16'h0000, 8'h00, ST_OK, 16'h0101, 8'h01, 4'hB, 1'b0, 1'b1}},
        '{K_RDATA, OP_NOP,       16'h0000, 8'h00, 1'b1,
          '{BUS_NONE, 16'h0000, 8'h00, ST_BAD_KIND, 16'h0101, 8'h01, 4'hB, 1'b0, 1'b1}},
        '{K_INSTR, OP_LD_B_B,    16'hFFFF, 8'hFF, 1'b1,
          '{BUS_NONE, 16'h0000, 8'h00, ST_UNSUP, 16'h0101, 8'h01, 4'hB, 1'b0, 1'b1}},
        '{K_INSTR, OP_ADD_HL_BC, 16'h0000, 8'h00, 1'b1,
          '{BUS_NONE, 16'h0000, 8'h00, ST_UNSUP, 16'h0101, 8'h01, 4'hB, 1'b0, 1'b1}},
        '{K_INSTR, OP_RST_38,    16'hFFFF, 8'hFF, 1'b1,
          '{BUS_NONE, 16'h0000, 8'h00, ST_UNSUP, 16'h0101, 8'h01, 4'hB, 1'b0, 1'b1}},
        '{K_INSTR, OP_LD_A_BC,   16'h0000, 8'h00, 1'b1,
          '{BUS_READ, 16'h0013, 8'h00, ST_OK, 16'h0102, 8'h01, 4'hB, 1'b0, 1'b1}},
        '{K_INSTR, OP_NOP,       16'h0000, 8'h00, 1'b1,
          '{BUS_NONE, 16'h0000, 8'h00, ST_BAD_KIND, 16'h0102, 8'h01, 4'hB, 1'b0, 1'b1}},
        '{K_RDATA, OP_NOP,       16'h0000, 8'hFF, 1'b1,
          '{BUS_NONE, 16'h0000, 8'h00, ST_OK, 16'h0102, 8'hFF, 4'hB, 1'b0, 1'b1}},
        '{K_INSTR, OP_LD_A16_SP, 16'hFFFF, 8'h00, 1'b0, NO_WANT},
        '{K_INSTR, OP_LD_SP_D16, 16'h0000, 8'h00, 1'b0, NO_WANT},
        '{K_INSTR, OP_LD_A16_SP, 16'h8000, 8'h00, 1'b0, NO_WANT},
        '{K_INSTR, OP_LD_BC_D16, 16'hFFFF, 8'h00, 1'b0, NO_WANT},
        '{K_INSTR, OP_LD_HL_D16, 16'hFFFF, 8'h00, 1'b0, NO_WANT},
        '{K_INSTR, OP_LDI_HL_A,  16'h0000, 8'h00, 1'b0, NO_WANT},
        '{K_INSTR, OP_LDD_A_HL,  16'h0000, 8'h00, 1'b0, NO_WANT},
        '{K_RDATA, OP_NOP,       16'h0000, 8'h00, 1'b0, NO_WANT},
        '{K_INSTR, OP_INC_MEM,   16'h0000, 8'h00, 1'b0, NO_WANT},
        '{K_RDATA, OP_NOP,       16'h0000, 8'hFF, 1'b0, NO_WANT},
        '{K_INSTR, OP_DEC_MEM,   16'h0000, 8'h00, 1'b0, NO_WANT},
        '{K_RDATA, OP_NOP,       16'h0000, 8'h00, 1'b0, NO_WANT},
        '{K_INSTR, OP_LD_MEM_D8, 16'h00AB, 8'h00, 1'b0, NO_WANT},
        '{K_INSTR, OP_LD_A_D8,   16'h009A, 8'h00, 1'b0, NO_WANT},
        '{K_INSTR, OP_DAA,       16'h0000, 8'h00, 1'b0, NO_WANT},
        '{K_INSTR, OP_CPL,       16'h0000, 8'h00, 1'b0, NO_WANT},
        '{K_INSTR, OP_DAA,       16'h0000, 8'h00, 1'b0, NO_WANT},
        '{K_INSTR, OP_JR,        16'h0080, 8'h00, 1'b0, NO_WANT},
        '{K_INSTR, OP_JR_NC,     16'h007F, 8'h00, 1'b0, NO_WANT},
        '{K_INSTR, OP_STOP,      16'hFFFF, 8'h00, 1'b0, NO_WANT}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;

    // CPU state as the predictor sees it
    logic [15:0] pc_q;
    logic [15:0] sp_q;
    logic [7:0]  r8 [0:7];
    logic [3:0]  flags;
    logic        stopped;
    mem_wait_t   mem_wait;

    result_t     due_results [$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned ready_hold = 0;

    sm83_low_quadrant_executor u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic logic [15:0] get_pair(input logic [1:0] p);
        case (p)
            PAIR_BC: return {r8[REG_B], r8[REG_C]};
            PAIR_DE: return {r8[REG_D], r8[REG_E]};
            PAIR_HL: return {r8[REG_H], r8[REG_L]};
            default: return sp_q;
        endcase
    endfunction

    task automatic set_pair(input logic [1:0] p, input logic [15:0] v);
        case (p)
            PAIR_BC: {r8[REG_B], r8[REG_C]} = v;
            PAIR_DE: {r8[REG_D], r8[REG_E]} = v;
            PAIR_HL: {r8[REG_H], r8[REG_L]} = v;
            default: sp_q = v;
        endcase
    endtask

    function automatic logic [7:0] inc8(input logic [7:0] v);
        flags[FLAG_H] = (v[3:0] == 4'hF);
        flags[FLAG_Z] = (v == 8'hFF);
        flags[FLAG_N] = 1'b0;
        return v + 8'd1;
    endfunction

    function automatic logic [7:0] dec8(input logic [7:0] v);
        flags[FLAG_H] = (v[3:0] == 4'h0);
        flags[FLAG_Z] = (v == 8'h01);
        flags[FLAG_N] = 1'b1;
        return v - 8'd1;
    endfunction

    // Queue one result carrying the current PC, A, flags and stop state
    task automatic add_result(input logic [1:0] op, input logic [15:0] addr,
                              input logic [7:0] wdata, input logic [1:0] st, input logic last);
        result_t r;
        r = '{op, addr, wdata, st, pc_q, r8[REG_A], flags, stopped, last};
        due_results.push_back(r);
    endtask

    // Apply one accepted item to the CPU state and queue its results
    task automatic execute_step(input logic kind, input logic [7:0] op,
                                input logic [15:0] imm, input logic [7:0] rd);
        logic [1:0] row;
        logic [2:0] code;
        logic [15:0] hl;
        logic [7:0] a;
        logic [7:0] adj;
        logic take;
        logic cin;
        logic cout;
        row  = op[5:4];
        code = op[5:3];

        // read data finishes the access in flight
        if (kind == K_RDATA)
        begin
            case (mem_wait)
                WAIT_NONE:
                    add_result(BUS_NONE, 16'h0000, 8'h00, ST_BAD_KIND, 1'b1);
                WAIT_LOAD_A:
                begin
                    r8[REG_A] = rd;
                    mem_wait  = WAIT_NONE;
                    add_result(BUS_NONE, 16'h0000, 8'h00, ST_OK, 1'b1);
                end
                default:
                begin
                    a = (mem_wait == WAIT_INC_MEM) ? inc8(rd) : dec8(rd);
                    mem_wait = WAIT_NONE;
                    add_result(BUS_WRITE, get_pair(PAIR_HL), a, ST_OK, 1'b1);
                end
            endcase
            return;
        end
        if (mem_wait != WAIT_NONE)
        begin
            add_result(BUS_NONE, 16'h0000, 8'h00, ST_BAD_KIND, 1'b1);
            return;
        end
        // upper quadrants and the ADD HL,rr column are not executed
        if (op[7:6] != 2'b00 || op[3:0] == 4'h9)
        begin
            add_result(BUS_NONE, 16'h0000, 8'h00, ST_UNSUP, 1'b1);
            return;
        end

        case (op[3:0])
            // NOP, LD (a16),SP, STOP and relative jumps
            4'h0, 4'h8:
            begin
                if (op == OP_NOP)
                    pc_q = pc_q + 16'd1;
                else if (op == OP_LD_A16_SP)
                begin
                    pc_q = pc_q + 16'd3;
                    add_result(BUS_WRITE, imm, sp_q[7:0], ST_OK, 1'b0);
                    add_result(BUS_WRITE, imm + 16'd1, sp_q[15:8], ST_OK, 1'b1);
                    return;
                end
                else
                begin
                    pc_q = pc_q + 16'd2;
                    if (op == OP_STOP)
                        stopped = 1'b1;
                    else
                    begin
                        case (op)
                            OP_JR:    take = 1'b1;
                            OP_JR_NZ: take = !flags[FLAG_Z];
                            OP_JR_Z:  take = flags[FLAG_Z];
                            OP_JR_NC: take = !flags[FLAG_C];
                            default:  take = flags[FLAG_C];
                        endcase
                        if (take)
                            pc_q = pc_q + {{8{imm[7]}}, imm[7:0]};
                    end
                end
            end
            // LD rr,d16
            4'h1:
            begin
                pc_q = pc_q + 16'd3;
                set_pair(row, imm);
            end
            // indirect A loads and stores; rows HL and SP mean HL+ and HL-
            4'h2, 4'hA:
            begin
                pc_q = pc_q + 16'd1;
                hl   = get_pair(row[1] ? PAIR_HL : row);
                if (row == PAIR_HL)
                    set_pair(PAIR_HL, hl + 16'd1);
                else if (row == PAIR_SP)
                    set_pair(PAIR_HL, hl - 16'd1);
                if (!op[3])
                    add_result(BUS_WRITE, hl, r8[REG_A], ST_OK, 1'b1);
                else
                begin
                    mem_wait = WAIT_LOAD_A;
                    add_result(BUS_READ, hl, 8'h00, ST_OK, 1'b1);
                end
                return;
            end
            4'h3:
            begin
                pc_q = pc_q + 16'd1;
                set_pair(row, get_pair(row) + 16'd1);
            end
            4'hB:
            begin
                pc_q = pc_q + 16'd1;
                set_pair(row, get_pair(row) - 16'd1);
            end
            // 8-bit INC/DEC; opcode bit 0 picks DEC
            4'h4, 4'h5, 4'hC, 4'hD:
            begin
                pc_q = pc_q + 16'd1;
                if (code == REG_MEM)
                begin
                    mem_wait = op[0] ? WAIT_DEC_MEM : WAIT_INC_MEM;
                    add_result(BUS_READ, get_pair(PAIR_HL), 8'h00, ST_OK, 1'b1);
                    return;
                end
                r8[code] = op[0] ? dec8(r8[code]) : inc8(r8[code]);
            end
            // LD r,d8
            4'h6, 4'hE:
            begin
                pc_q = pc_q + 16'd2;
                if (code == REG_MEM)
                begin
                    add_result(BUS_WRITE, get_pair(PAIR_HL), imm[7:0], ST_OK, 1'b1);
                    return;
                end
                r8[code] = imm[7:0];
            end
            // accumulator and flag operations
            default:
            begin
                a    = r8[REG_A];
                cin  = flags[FLAG_C];
                cout = 1'b0;
                pc_q = pc_q + 16'd1;
                case (op)
                    OP_RLCA:
                    begin
                        cout = a[7];
                        a    = {a[6:0], a[7]};
                    end
                    OP_RRCA:
                    begin
                        cout = a[0];
                        a    = {a[0], a[7:1]};
                    end
                    OP_RLA:
                    begin
                        cout = a[7];
                        a    = {a[6:0], cin};
                    end
                    OP_RRA:
                    begin
                        cout = a[0];
                        a    = {cin, a[7:1]};
                    end
                    OP_DAA:
                    begin
                        adj  = 8'h00;
                        cout = cin;
                        if (flags[FLAG_N])
                        begin
                            if (flags[FLAG_H])
                                adj = adj | DAA_LO_ADJ;
                            if (cin)
                                adj = adj | DAA_HI_ADJ;
                            a = a - adj;
                        end
                        else
                        begin
                            if (flags[FLAG_H] || a[3:0] > DAA_LO_MAX)
                                adj = adj | DAA_LO_ADJ;
                            if (cin || a > DAA_HI_MAX)
                            begin
                                adj  = adj | DAA_HI_ADJ;
                                cout = 1'b1;
                            end
                            a = a + adj;
                        end
                        r8[REG_A]     = a;
                        flags[FLAG_Z] = (a == 8'h00);
                        flags[FLAG_H] = 1'b0;
                        flags[FLAG_C] = cout;
                    end
                    OP_CPL:
                    begin
                        r8[REG_A]     = ~a;
                        flags[FLAG_N] = 1'b1;
                        flags[FLAG_H] = 1'b1;
                    end
                    default:
                    begin
                        flags[FLAG_N] = 1'b0;
                        flags[FLAG_H] = 1'b0;
                        flags[FLAG_C] = (op == OP_SCF) ? 1'b1 : !cin;
                    end
                endcase
                // rotates leave only the carry set
                if (op <= OP_RRA)
                begin
                    r8[REG_A]     = a;
                    flags         = '0;
                    flags[FLAG_C] = cout;
                end
            end
        endcase
        add_result(BUS_NONE, 16'h0000, 8'h00, ST_OK, 1'b1);
    endtask

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    // Present one item after an idle gap and hold it until the transaction completes
    task automatic send_item(input logic kind, input logic [7:0] op, input logic [15:0] imm,
                             input logic [7:0] rd, input int unsigned gap);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {rd, imm, op};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned pick_gap(input logic calm);
        int unsigned r;
        r = $urandom_range(99);
        if (calm || r < 65)
            return 0;
        if (r < 88)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(8, 4);
        return $urandom_range(40, 15);
    endfunction

    initial
    begin : stimulus
        int          n;
        int          i;
        int unsigned r;
        logic        kind;
        logic [7:0]  op;
        logic [15:0] imm;
        logic [7:0]  rd;

        // power-on state of the predictor
        pc_q      = PC_RESET;
        sp_q      = SP_RESET;
        r8[REG_A] = A_RESET;
        {r8[REG_B], r8[REG_C]} = BC_RESET;
        {r8[REG_D], r8[REG_E]} = DE_RESET;
        {r8[REG_H], r8[REG_L]} = HL_RESET;
        r8[REG_MEM] = 8'h00;
        flags     = F_RESET;
        stopped   = 1'b0;
        mem_wait  = WAIT_NONE;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_item(PLAN[i].kind, PLAN[i].op, PLAN[i].imm, PLAN[i].rd,
                      pick_gap(i < 10));
            n = due_results.size();
            execute_step(PLAN[i].kind, PLAN[i].op, PLAN[i].imm, PLAN[i].rd);
            if (PLAN[i].typed)
            begin
                while (due_results.size() > n)
                    void'(due_results.pop_back());
                due_results.push_back(PLAN[i].want);
            end
        end

        // random part: mostly well-formed sequences, reads answered most of the time
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            // now and then hold off until the output side has caught up
            if (i % 400 == 399)
            begin
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (due_results.size() != 0);
            end

            kind = K_INSTR;
            op   = 8'($urandom_range(255));
            imm  = 16'($urandom);
            rd   = 8'($urandom);
            r    = $urandom_range(99);
            case ($urandom_range(15))
                0: imm = 16'h0000;
                1: imm = 16'hFFFF;
                2: imm = {8'($urandom), 8'h80};
                3: imm = {8'($urandom), 8'h7F};
                default: ;
            endcase
            case ($urandom_range(11))
                0: rd = 8'h00;
                1: rd = 8'hFF;
                2: rd = 8'h0F;
                default: ;
            endcase

            if (mem_wait != WAIT_NONE)
            begin
                if (r < 88)
                    kind = K_RDATA;
            end
            else if (r < 4)
                kind = K_RDATA;
            else if (r < 10)
            begin
                if ($urandom_range(1) == 0)
                    op = 8'($urandom_range(255, 64));
                else
                    op = {2'b00, 2'($urandom_range(3)), 4'h9};
            end
            else
            begin
                do
                    op = 8'($urandom_range(63));
                while (op[3:0] == 4'h9);
            end

            send_item(kind, op, imm, rd, pick_gap((i % 300) < 60));
            execute_step(kind, op, imm, rd);
        end

        // drain, then allow a margin for anything unexpected to show up
        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Output side
    // ---------------------------------------------------------------
    // Random backpressure with calm stretches of full throughput
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            ready_hold <= 0;
        end
        else if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if (cycles[10:9] == 2'b00 || $urandom_range(99) < 65)
        begin
            m_tready   <= 1'b1;
            ready_hold <= $urandom_range(3);
        end
        else
        begin
            m_tready   <= 1'b0;
            ready_hold <= ($urandom_range(19) == 0) ? $urandom_range(40, 15) : $urandom_range(3);
        end
    end

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare each result transaction with the oldest expected one
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h last %b",
                         $time, m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("bus_op",       16'(want.bus_op),    16'(m_tdata[1:0]));
                check_field("bus_addr",     want.bus_addr,       m_tdata[17:2]);
                check_field("bus_wdata",    16'(want.bus_wdata), 16'(m_tdata[25:18]));
                check_field("status",       16'(want.status),    16'(m_tdata[27:26]));
                check_field("prog_counter", want.pc,             m_tdata[43:28]);
                check_field("accumulator",  16'(want.acc),       16'(m_tdata[51:44]));
                check_field("flag_bits",    16'(want.flags),     16'(m_tdata[55:52]));
                check_field("is_stopped",   16'(want.stopped),   16'(m_tdata[56]));
                check_field("last",         16'(want.last),      16'(m_tlast));
            end
        end
    end

    // Run-away guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, due_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
